/* hw/rtl/lru_pkg.sv */
// Shared types and constants for the LRU key-value cache.
package lru_pkg;

  localparam int unsigned KEY_FIELD_W = 10;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned CAP_W       = 5;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [VAL_W-1:0] PUT_VALUE  = '0;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  // Per-cell control from the row controller.
  typedef struct packed {
    logic in_use;  // cell holds a live entry
    logic shift;   // take the neighbor's entry, or the request at the front, this cycle
  } cell_ctl_t;

endpackage

/* hw/rtl/lru_if.sv */
// Request and response channel interfaces for the LRU key-value cache.
interface lru_req_if
  import lru_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [KEY_FIELD_W-1:0]  key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

interface lru_rsp_if
  import lru_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, hit, read_value, occupancy, input ready);
  modport sink   (input valid, hit, read_value, occupancy, output ready);
endinterface

/* hw/rtl/lru_cell.sv */
// One entry cell of the recency-ordered row: holds a key and value, compares, shifts.
module lru_cell
  import lru_pkg::*;
#(
  parameter int KEY_BITS = 10
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [KEY_BITS-1:0] search_key,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic [VAL_W-1:0]    prev_value,
  output logic                match,
  output logic [KEY_BITS-1:0] key,
  output logic [VAL_W-1:0]    value
);

  logic [KEY_BITS-1:0] key_r;
  logic [VAL_W-1:0]    value_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r   <= prev_key;
      value_r <= prev_value;
    end
  end

  assign match = ctl.in_use && (key_r == search_key);
  assign key   = key_r;
  assign value = value_r;

endmodule

/* hw/rtl/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: a row of entry cells with recency order by position.
//
//   channel   dir  handshake          payload
//   in_req    in   valid/ready        func, key, value
//   out_rsp   out  valid/ready        hit, read_value, occupancy
//   cfg       in   cfg_we             cfg_wdata (capacity)
//
// All cells compare the key at once and the row shifts toward the back in the same cycle,
// so a beat can be accepted every cycle while the skid register is empty.
// A result register plus one skid register sit on the output; in_req stalls only when
// both hold results. Reset empties the cache and sets capacity to 16; no clearing pass.
module lru_key_value_cache
  import lru_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  lru_req_if.sink          in_req,
  lru_rsp_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  rsp_t             out_r, out_nxt, skid_r, skid_nxt;

  logic                accept, out_fire, is_put, hit, put_miss, evict;
  logic [KEY_BITS-1:0] search_key;
  logic [VAL_W-1:0]    hit_value, front_value;
  logic [CMP_W-1:0]    cap_eff, count_ext;
  rsp_t                new_rsp;

  logic [ENTRIES-1:0]  match;
  logic [ENTRIES:0]    at_or_after;
  logic [KEY_BITS-1:0] cell_key   [ENTRIES];
  logic [VAL_W-1:0]    cell_value [ENTRIES];
  cell_ctl_t           cell_ctl   [ENTRIES];

  assign in_req.ready = !skid_v_r;
  assign accept       = in_req.valid && in_req.ready;
  assign out_fire     = out_v_r && out_rsp.ready;
  assign is_put       = (func_t'(in_req.func) == FUNC_PUT);
  assign search_key   = KEY_BITS'(in_req.key);

  // at_or_after[i] is set when the matching entry sits at position i or further back.
  assign at_or_after[ENTRIES] = 1'b0;
  assign hit                  = at_or_after[0];
  assign put_miss             = is_put && !hit;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) hit_value = hit_value | cell_value[i];
    end
  end

  assign front_value = is_put ? VAL_W'(in_req.value) : hit_value;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      assign at_or_after[g]    = match[g] | at_or_after[g+1];
      assign cell_ctl[g].in_use = (count_r > CNT_W'(g));
      assign cell_ctl[g].shift  = accept && ((hit && at_or_after[g]) || put_miss);

      if (g == 0) begin : g_front
        lru_cell #(.KEY_BITS(KEY_BITS)) u_cell (
          .clk        (clk),
          .ctl        (cell_ctl[g]),
          .search_key (search_key),
          .prev_key   (search_key),
          .prev_value (front_value),
          .match      (match[g]),
          .key        (cell_key[g]),
          .value      (cell_value[g])
        );
      end else begin : g_rest
        lru_cell #(.KEY_BITS(KEY_BITS)) u_cell (
          .clk        (clk),
          .ctl        (cell_ctl[g]),
          .search_key (search_key),
          .prev_key   (cell_key[g-1]),
          .prev_value (cell_value[g-1]),
          .match      (match[g]),
          .key        (cell_key[g]),
          .value      (cell_value[g])
        );
      end
    end
  endgenerate

  // Effective capacity: zero counts as one, anything above the row size saturates.
  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_eff == '0) cap_eff = CMP_W'(1);
    if (cap_eff > CMP_W'(ENTRIES)) cap_eff = CMP_W'(ENTRIES);
  end

  assign count_ext = CMP_W'(count_r);
  assign evict     = (count_ext >= cap_eff);

  always_comb begin
    count_nxt = count_r;
    if (accept && put_miss && !evict) count_nxt = count_r + CNT_W'(1);
  end

  always_comb begin
    new_rsp.hit       = hit;
    new_rsp.occupancy = OCC_W'(count_nxt);
    if (is_put) begin
      new_rsp.read_value = PUT_VALUE;
    end else if (hit) begin
      new_rsp.read_value = hit_value;
    end else begin
      new_rsp.read_value = MISS_VALUE;
    end
  end

  // Output register with a skid stage behind it.
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (out_fire || !out_v_r) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = new_rsp;
        out_v_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt   = new_rsp;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_W'(16);
      count_r  <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      count_r  <= count_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_rsp.valid      = out_v_r;
  assign out_rsp.hit        = out_r.hit;
  assign out_rsp.read_value = out_r.read_value;
  assign out_rsp.occupancy  = out_r.occupancy;

endmodule

/* hw/rtl/lru_checker.sv */
// Port-level checker for the LRU key-value cache, bound to the top level.
module lru_checker
  import lru_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_hit,
  input logic signed [VAL_W-1:0] out_read_value,
  input logic [OCC_W-1:0]        out_occupancy
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit) && $stable(out_read_value)
                                && $stable(out_occupancy))
    else $error("result beat changed while stalled");

  // A hit means the entry was present and still is, so the cache cannot be empty.
  a_hit_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_occupancy != '0)
    else $error("hit reported with zero occupancy");

  // The request side stalls only when a result is already waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("request stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_key_value_cache lru_checker u_lru_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_hit        (out_rsp.hit),
  .out_read_value (out_rsp.read_value),
  .out_occupancy  (out_rsp.occupancy)
);
